// ===== rtl/core/ltmd_pkg.sv =====
// Shared types, codes and helpers for the line tracking motor drive unit.
// Has no dependencies; every other file in rtl/core imports it.

package ltmd_pkg;

	localparam int SPEED_W = 11;
	localparam int WORK_W  = 14;
	localparam int ACCUM_W = 12;
	localparam int DUTY_W  = 10;
	localparam int DROP_W  = ACCUM_W + 1;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic signed [WORK_W-1:0]  work_t;
	typedef logic [ACCUM_W-1:0]        accum_t;
	typedef logic [DROP_W-1:0]         drop_t;
	typedef logic [DUTY_W-1:0]         duty_t;

	// Steering modes held in the control_mode register.
	typedef enum logic [1:0] {
		MODE_BANG   = 2'd0,
		MODE_REDUCE = 2'd1,
		MODE_SMOOTH = 2'd2,
		MODE_HOLD   = 2'd3
	} mode_t;

	// Sensed line position codes.
	typedef enum logic [2:0] {
		POS_LEFT      = 3'd0,
		POS_RIGHT     = 3'd1,
		POS_CENTER    = 3'd2,
		POS_FAR_LEFT  = 3'd3,
		POS_FAR_RIGHT = 3'd4,
		POS_NONE      = 3'd5
	} pos_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_CONTROL_MODE = 3'd0,
		CFG_BASE_SPEED   = 3'd1,
		CFG_INNER_CUT    = 3'd2,
		CFG_SPEED_FLOOR  = 3'd3,
		CFG_TRIM_L       = 3'd4,
		CFG_TRIM_R       = 3'd5
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Request type codes.
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_ENABLE = 1'b1;

	// Speed limit and accumulator constants (accumulator in 0.05 units).
	localparam work_t  SPEED_MAX    = 14'sd1000;
	localparam speed_t SPEED_LIMIT  = 11'sd1000;
	localparam accum_t ACCUM_CAP    = 12'd1600;
	localparam accum_t ACCUM_GROW   = 12'd2;
	localparam accum_t ACCUM_SETTLE = 12'd5;

	typedef struct packed {
		mode_t              control_mode;
		logic [9:0]         base_speed;
		logic [9:0]         inner_cut;
		logic [9:0]         speed_floor;
		logic signed [7:0]  trim_l;
		logic signed [7:0]  trim_r;
	} cfg_t;

	typedef struct packed {
		duty_t left_fwd_duty;
		duty_t left_rev_duty;
		duty_t right_fwd_duty;
		duty_t right_rev_duty;
		logic  left_reverse;
		logic  right_reverse;
		logic  bridge_cycled;
	} result_t;

	// Saturate a working value to the speed range.
	function automatic speed_t sat_speed(work_t v);
		speed_t r;
		if (v > SPEED_MAX) begin
			r = SPEED_LIMIT;
		end else if (v < -SPEED_MAX) begin
			r = -SPEED_LIMIT;
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

	// Forward channel duty of one motor.
	function automatic duty_t fwd_duty(speed_t s, logic rev);
		duty_t r;
		if (rev || s[SPEED_W-1]) begin
			r = '0;
		end else begin
			r = s[DUTY_W-1:0];
		end
		return r;
	endfunction

	// Reverse channel duty of one motor.
	function automatic duty_t rev_duty(speed_t s, logic rev);
		speed_t n;
		duty_t r;
		n = -s;
		if (rev && s[SPEED_W-1]) begin
			r = n[DUTY_W-1:0];
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/ltmd_ifs.sv =====
// Request and result channel interfaces of the line tracking motor drive unit.
// Depends on ltmd_pkg for the duty type.

interface ltmd_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [2:0] line_position;

	modport source (output valid, output req_type, output line_position, input ready);
	modport sink (input valid, input req_type, input line_position, output ready);
endinterface

interface ltmd_rsp_if;
	import ltmd_pkg::*;

	logic  valid;
	logic  ready;
	duty_t left_fwd_duty;
	duty_t left_rev_duty;
	duty_t right_fwd_duty;
	duty_t right_rev_duty;
	logic  left_reverse;
	logic  right_reverse;
	logic  bridge_cycled;

	modport source (output valid, output left_fwd_duty, output left_rev_duty,
		output right_fwd_duty, output right_rev_duty, output left_reverse,
		output right_reverse, output bridge_cycled, input ready);
	modport sink (input valid, input left_fwd_duty, input left_rev_duty,
		input right_fwd_duty, input right_rev_duty, input left_reverse,
		input right_reverse, input bridge_cycled, output ready);
endinterface

// ===== rtl/core/ltmd_cfg_regs.sv =====
// Configuration register file of the line tracking motor drive unit.
// Depends on ltmd_pkg for the register indexes and the cfg_t bundle.

module ltmd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ltmd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ltmd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ltmd_pkg::cfg_t                      cfg
);
	import ltmd_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_mode <= MODE_BANG;
			cfg_q.base_speed   <= 10'd1000;
			cfg_q.inner_cut    <= 10'd100;
			cfg_q.speed_floor  <= 10'd0;
			cfg_q.trim_l       <= 8'sd0;
			cfg_q.trim_r       <= 8'sd0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CONTROL_MODE: cfg_q.control_mode <= mode_t'(cfg_data[1:0]);
				CFG_BASE_SPEED:   cfg_q.base_speed <= cfg_data;
				CFG_INNER_CUT:    cfg_q.inner_cut <= cfg_data;
				CFG_SPEED_FLOOR:  cfg_q.speed_floor <= cfg_data;
				CFG_TRIM_L:       cfg_q.trim_l <= cfg_data[7:0];
				CFG_TRIM_R:       cfg_q.trim_r <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/ltmd_track_core.sv =====
// Steering state and next-state logic: error accumulator, motor speeds and
// directions, and the duty result of one request. Depends on ltmd_pkg.

module ltmd_track_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltmd_pkg::cfg_t       cfg,
	input  logic                 step,
	input  logic                 item_req_type,
	input  logic [2:0]           item_position,
	output ltmd_pkg::result_t    result
);
	import ltmd_pkg::*;

	accum_t accum_q;
	speed_t left_speed_q;
	speed_t right_speed_q;
	logic   left_dir_q;
	logic   right_dir_q;

	work_t  auto_w;
	work_t  ltrim_w;
	work_t  rtrim_w;
	work_t  red_w;
	speed_t left_cruise;
	speed_t right_cruise;
	speed_t left_reduced;
	speed_t right_reduced;
	accum_t accum_grow;
	accum_t accum_settle;
	drop_t  near_drop;
	drop_t  far_drop;

	accum_t accum_n;
	speed_t left_n;
	speed_t right_n;
	logic   left_dir_n;
	logic   right_dir_n;
	logic   apply;
	logic   cycled;

	// Lower a speed by the accumulator drop, hold it at the minimum, saturate.
	function automatic speed_t track(speed_t cur, drop_t drop, logic [9:0] min_speed);
		work_t c;
		work_t d;
		work_t m;
		work_t v;
		c = {{(WORK_W-SPEED_W){cur[SPEED_W-1]}}, cur};
		d = {{(WORK_W-DROP_W){1'b0}}, drop};
		m = {{(WORK_W-10){1'b0}}, min_speed};
		v = c - d;
		if (v < m) begin
			v = m;
		end
		return sat_speed(v);
	endfunction

	// Cruise speeds with trim, with and without the reduction step.
	always_comb begin
		auto_w = {{(WORK_W-10){1'b0}}, cfg.base_speed};
		red_w = {{(WORK_W-10){1'b0}}, cfg.inner_cut};
		ltrim_w = {{(WORK_W-8){cfg.trim_l[7]}}, cfg.trim_l};
		rtrim_w = {{(WORK_W-8){cfg.trim_r[7]}}, cfg.trim_r};
		left_cruise = sat_speed(auto_w + ltrim_w);
		right_cruise = sat_speed(auto_w + rtrim_w);
		left_reduced = sat_speed(auto_w + ltrim_w - red_w);
		right_reduced = sat_speed(auto_w + rtrim_w - red_w);
	end

	// Accumulator grows on every update while below its cap, then may settle toward zero.
	always_comb begin
		accum_grow = (accum_q < ACCUM_CAP) ? accum_q + ACCUM_GROW : accum_q;
		accum_settle = (accum_grow > ACCUM_SETTLE) ? accum_grow - ACCUM_SETTLE : '0;
		near_drop = {1'b0, accum_settle};
		far_drop = {accum_grow, 1'b0};
	end

	// Speed selection by request type, mode and line position.
	always_comb begin
		accum_n = accum_q;
		left_n = left_speed_q;
		right_n = right_speed_q;
		apply = 1'b0;
		if (item_req_type == REQ_ENABLE) begin
			left_n = '0;
			right_n = '0;
		end else begin
			accum_n = accum_grow;
			case (pos_t'(item_position))
				POS_LEFT: begin
					case (cfg.control_mode)
						MODE_BANG: begin
							apply = 1'b1;
							left_n = left_cruise;
							right_n = right_cruise;
						end
						MODE_REDUCE: begin
							apply = 1'b1;
							left_n = left_reduced;
							right_n = right_cruise;
						end
						MODE_SMOOTH: begin
							apply = 1'b1;
							accum_n = accum_settle;
							left_n = track(left_speed_q, near_drop, cfg.speed_floor);
						end
						default: begin
						end
					endcase
				end
				POS_RIGHT: begin
					case (cfg.control_mode)
						MODE_BANG: begin
							apply = 1'b1;
							left_n = left_cruise;
							right_n = right_cruise;
						end
						MODE_REDUCE: begin
							apply = 1'b1;
							left_n = left_cruise;
							right_n = right_reduced;
						end
						MODE_SMOOTH: begin
							apply = 1'b1;
							accum_n = accum_settle;
							right_n = track(right_speed_q, near_drop, cfg.speed_floor);
						end
						default: begin
						end
					endcase
				end
				POS_CENTER: begin
					apply = 1'b1;
					left_n = left_cruise;
					right_n = right_cruise;
					if (cfg.control_mode == MODE_SMOOTH) begin
						accum_n = accum_settle;
					end
				end
				POS_FAR_LEFT: begin
					case (cfg.control_mode)
						MODE_BANG, MODE_REDUCE: begin
							apply = 1'b1;
							left_n = '0;
							right_n = right_cruise;
						end
						MODE_SMOOTH: begin
							apply = 1'b1;
							left_n = track(left_speed_q, far_drop, cfg.speed_floor);
						end
						default: begin
						end
					endcase
				end
				POS_FAR_RIGHT: begin
					case (cfg.control_mode)
						MODE_BANG, MODE_REDUCE: begin
							apply = 1'b1;
							left_n = left_cruise;
							right_n = '0;
						end
						MODE_SMOOTH: begin
							apply = 1'b1;
							right_n = track(right_speed_q, far_drop, cfg.speed_floor);
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// Direction follows the sign of an applied speed; enable forces forward.
	always_comb begin
		if (item_req_type == REQ_ENABLE) begin
			left_dir_n = 1'b0;
			right_dir_n = 1'b0;
		end else if (apply) begin
			left_dir_n = left_n[SPEED_W-1];
			right_dir_n = right_n[SPEED_W-1];
		end else begin
			left_dir_n = left_dir_q;
			right_dir_n = right_dir_q;
		end
		cycled = (item_req_type != REQ_ENABLE) && apply &&
			((left_dir_n != left_dir_q) || (right_dir_n != right_dir_q));
	end

	// Result fields from the new state.
	always_comb begin
		result.left_fwd_duty = fwd_duty(left_n, left_dir_n);
		result.left_rev_duty = rev_duty(left_n, left_dir_n);
		result.right_fwd_duty = fwd_duty(right_n, right_dir_n);
		result.right_rev_duty = rev_duty(right_n, right_dir_n);
		result.left_reverse = left_dir_n;
		result.right_reverse = right_dir_n;
		result.bridge_cycled = cycled;
	end

	// State registers advance once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			left_speed_q <= '0;
			right_speed_q <= '0;
			left_dir_q <= 1'b0;
			right_dir_q <= 1'b0;
		end else if (step) begin
			accum_q <= accum_n;
			left_speed_q <= left_n;
			right_speed_q <= right_n;
			left_dir_q <= left_dir_n;
			right_dir_q <= right_dir_n;
		end
	end

`ifndef SYNTHESIS
	a_accum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accum_q < ACCUM_CAP + ACCUM_GROW)
		else $error("error accumulator above its cap");
	a_left_dir_sign: assert property (@(posedge clk) disable iff (!arst_n)
		left_dir_q == left_speed_q[SPEED_W-1])
		else $error("left direction disagrees with left speed sign");
	a_right_dir_sign: assert property (@(posedge clk) disable iff (!arst_n)
		right_dir_q == right_speed_q[SPEED_W-1])
		else $error("right direction disagrees with right speed sign");
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(left_speed_q <= SPEED_LIMIT) && (left_speed_q >= -SPEED_LIMIT) &&
		(right_speed_q <= SPEED_LIMIT) && (right_speed_q >= -SPEED_LIMIT))
		else $error("motor speed outside the saturation range");
`endif

endmodule

// ===== rtl/core/line_tracking_motor_drive_unit.sv =====
// Line tracking motor drive unit: a request is registered in the input stage, its new
// speeds and duties are computed combinationally and held in the result register.
// An accepted request passes the input stage and then the result register; a stall holds it.
// Throughput: one request per cycle while the result side is not stalled.
// Reset (arst_n low, asynchronous): speeds and accumulator zero, both motors
// forward, registers at their defaults, both channels empty.

module line_tracking_motor_drive_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	ltmd_req_if.sink                            req,
	ltmd_rsp_if.source                          rsp,
	input  logic                                cfg_wr_en,
	input  logic [ltmd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ltmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ltmd_pkg::*;

	cfg_t    cfg;
	result_t result;
	result_t result_q;
	logic    rsp_valid_q;
	logic    valid_s1;
	logic    req_type_s1;
	logic [2:0] position_s1;
	logic    advance;

	ltmd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ltmd_track_core u_track_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.step          (advance),
		.item_req_type (req_type_s1),
		.item_position (position_s1),
		.result        (result)
	);

	// The registered request moves on when the result register is free or drains.
	assign advance = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			position_s1 <= req.line_position;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.left_fwd_duty = result_q.left_fwd_duty;
	assign rsp.left_rev_duty = result_q.left_rev_duty;
	assign rsp.right_fwd_duty = result_q.right_fwd_duty;
	assign rsp.right_rev_duty = result_q.right_rev_duty;
	assign rsp.left_reverse = result_q.left_reverse;
	assign rsp.right_reverse = result_q.right_reverse;
	assign rsp.bridge_cycled = result_q.bridge_cycled;

`ifndef SYNTHESIS
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed request did not reach the result register");
	a_stage_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp.ready) |-> !req.ready)
		else $error("request taken while the input stage is blocked");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(result_q)))
		else $error("waiting result changed or was dropped");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the line tracking motor drive unit: directed rows, then phased random
// requests, with a request-level predictor of speeds, directions and the tracking accumulator.
// Depends on ltmd_pkg, the ltmd_req_if / ltmd_rsp_if interfaces and the unit's RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ltmd_pkg::*;

	// Line codes outside the named set; the unit must treat them like no line.
	localparam logic [2:0] POS_SPARE6 = 3'd6;
	localparam logic [2:0] POS_SPARE7 = 3'd7;
	// Register index that maps to no register.
	localparam logic [2:0] CFG_IDX_SPARE = 3'd6;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 175;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// One row of the directed table: either a register setting or a request.
	typedef struct packed {
		logic       is_cfg;
		cfg_t       cfg;
		logic       rtype;
		logic [2:0] pos;
		logic       known;
		result_t    want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ltmd_req_if req_if ();
	ltmd_rsp_if rsp_if ();

	line_tracking_motor_drive_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Mirror of the unit's registers and motor state.
	cfg_t   cfg_m;
	accum_t accum_m = '0;
	speed_t lspd_m  = '0;
	speed_t rspd_m  = '0;
	logic   ldir_m  = 1'b0;
	logic   rdir_m  = 1'b0;

	result_t owed_drive [$];
	result_t known_exp;
	logic    known_valid = 1'b0;

	int  mismatches   = 0;
	int  accepted     = 0;
	int  enables      = 0;
	int  results_seen = 0;
	int  flips        = 0;
	int  accum_peak   = 0;
	int  hold_cycles  = 0;
	bit  tx_idle      = 1'b1;
	bit  rx_idle      = 1'b1;

	function automatic cfg_t regs(mode_t m, int a, int r, int mn, int lt, int rt);
		cfg_t c;
		c.control_mode = m;
		c.base_speed   = a[9:0];
		c.inner_cut    = r[9:0];
		c.speed_floor  = mn[9:0];
		c.trim_l       = lt[7:0];
		c.trim_r       = rt[7:0];
		return c;
	endfunction

	function automatic result_t duty(int lf, int lr, int rf, int rr, int lrev, int rrev, int cyc);
		result_t d;
		d.left_fwd_duty  = lf[9:0];
		d.left_rev_duty  = lr[9:0];
		d.right_fwd_duty = rf[9:0];
		d.right_rev_duty = rr[9:0];
		d.left_reverse   = lrev[0];
		d.right_reverse  = rrev[0];
		d.bridge_cycled  = cyc[0];
		return d;
	endfunction

	function automatic plan_row_t row_item(logic rt, logic [2:0] pos);
		plan_row_t p;
		p = '0;
		p.rtype = rt;
		p.pos   = pos;
		return p;
	endfunction

	function automatic plan_row_t row_known(logic rt, logic [2:0] pos, result_t w);
		plan_row_t p;
		p = row_item(rt, pos);
		p.known = 1'b1;
		p.want  = w;
		return p;
	endfunction

	function automatic plan_row_t row_regs(cfg_t c);
		plan_row_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.cfg    = c;
		return p;
	endfunction

	function automatic int clamp_speed(int v);
		int s;
		s = v;
		if (s > int'(SPEED_LIMIT)) begin
			s = int'(SPEED_LIMIT);
		end else if (s < -int'(SPEED_LIMIT)) begin
			s = -int'(SPEED_LIMIT);
		end
		return s;
	endfunction

	// Smooth tracking: drop the speed, hold it at the floor, then saturate.
	function automatic int track_speed(int cur, int drop);
		int t;
		t = cur - drop;
		if (t < int'(cfg_m.speed_floor)) begin
			t = int'(cfg_m.speed_floor);
		end
		return clamp_speed(t);
	endfunction

	// Advance the mirrored state by one request and return the duties it produces.
	function automatic result_t drive_step(logic rt, logic [2:0] pos);
		int lc, rc, lr, rr, ls, rs, acc, cruise_l, cruise_r, neg;
		logic go, flip;
		result_t d;
		go   = 1'b0;
		flip = 1'b0;
		ls   = int'(lspd_m);
		rs   = int'(rspd_m);
		if (rt == REQ_ENABLE) begin
			ls     = 0;
			rs     = 0;
			ldir_m = 1'b0;
			rdir_m = 1'b0;
		end else begin
			cruise_l = int'(cfg_m.base_speed) + int'(cfg_m.trim_l);
			cruise_r = int'(cfg_m.base_speed) + int'(cfg_m.trim_r);
			lc = clamp_speed(cruise_l);
			rc = clamp_speed(cruise_r);
			lr = clamp_speed(cruise_l - int'(cfg_m.inner_cut));
			rr = clamp_speed(cruise_r - int'(cfg_m.inner_cut));
			acc = int'(accum_m);
			if (acc < int'(ACCUM_CAP)) begin
				acc = acc + int'(ACCUM_GROW);
			end
			case (pos)
				POS_LEFT, POS_RIGHT: begin
					if (cfg_m.control_mode == MODE_BANG) begin
						ls = lc;
						rs = rc;
						go = 1'b1;
					end else if (cfg_m.control_mode == MODE_REDUCE) begin
						ls = (pos == POS_LEFT) ? lr : lc;
						rs = (pos == POS_LEFT) ? rc : rr;
						go = 1'b1;
					end else if (cfg_m.control_mode == MODE_SMOOTH) begin
						acc = (acc > int'(ACCUM_SETTLE)) ? acc - int'(ACCUM_SETTLE) : 0;
						if (pos == POS_LEFT) begin
							ls = track_speed(ls, acc);
						end else begin
							rs = track_speed(rs, acc);
						end
						go = 1'b1;
					end
				end
				POS_CENTER: begin
					ls = lc;
					rs = rc;
					go = 1'b1;
					if (cfg_m.control_mode == MODE_SMOOTH) begin
						acc = (acc > int'(ACCUM_SETTLE)) ? acc - int'(ACCUM_SETTLE) : 0;
					end
				end
				POS_FAR_LEFT, POS_FAR_RIGHT: begin
					if (cfg_m.control_mode == MODE_BANG || cfg_m.control_mode == MODE_REDUCE) begin
						ls = (pos == POS_FAR_LEFT) ? 0 : lc;
						rs = (pos == POS_FAR_LEFT) ? rc : 0;
						go = 1'b1;
					end else if (cfg_m.control_mode == MODE_SMOOTH) begin
						// Far positions take twice the accumulator and never settle it.
						if (pos == POS_FAR_LEFT) begin
							ls = track_speed(ls, 2 * acc);
						end else begin
							rs = track_speed(rs, 2 * acc);
						end
						go = 1'b1;
					end
				end
				default: begin
				end
			endcase
			accum_m = acc[ACCUM_W-1:0];
		end
		// A sign change flips the motor and cycles the bridge.
		if (go) begin
			if (ldir_m != (ls < 0)) begin
				ldir_m = (ls < 0);
				flip   = 1'b1;
			end
			if (rdir_m != (rs < 0)) begin
				rdir_m = (rs < 0);
				flip   = 1'b1;
			end
		end
		lspd_m = ls[SPEED_W-1:0];
		rspd_m = rs[SPEED_W-1:0];
		d.left_fwd_duty  = (ldir_m || ls < 0) ? '0 : ls[DUTY_W-1:0];
		neg = -ls;
		d.left_rev_duty  = (ldir_m && ls < 0) ? neg[DUTY_W-1:0] : '0;
		d.right_fwd_duty = (rdir_m || rs < 0) ? '0 : rs[DUTY_W-1:0];
		neg = -rs;
		d.right_rev_duty = (rdir_m && rs < 0) ? neg[DUTY_W-1:0] : '0;
		d.left_reverse   = ldir_m;
		d.right_reverse  = rdir_m;
		d.bridge_cycled  = flip;
		return d;
	endfunction

	function automatic void field_check(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
			end
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous ceiling on the whole run.
	initial begin
		#400_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				hold_left   = hold_cycles;
				hold_cycles = 0;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (rx_idle) begin
				rsp_if.ready <= ($urandom_range(99) >= 34);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Mirror register writes, predict each accepted request and check each result.
	always @(posedge clk) begin : duty_watch
		result_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CONTROL_MODE: cfg_m.control_mode = mode_t'(cfg_data[1:0]);
					CFG_BASE_SPEED:   cfg_m.base_speed   = cfg_data;
					CFG_INNER_CUT:    cfg_m.inner_cut    = cfg_data;
					CFG_SPEED_FLOOR:  cfg_m.speed_floor  = cfg_data;
					CFG_TRIM_L:       cfg_m.trim_l       = cfg_data[7:0];
					CFG_TRIM_R:       cfg_m.trim_r       = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (req_if.valid && req_if.ready) begin
				want = drive_step(req_if.req_type, req_if.line_position);
				if (known_valid) begin
					want = known_exp;
				end
				owed_drive.push_back(want);
				accepted++;
				if (req_if.req_type == REQ_ENABLE) begin
					enables++;
				end
				if (int'(accum_m) > accum_peak) begin
					accum_peak = int'(accum_m);
				end
			end
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (rsp_if.bridge_cycled) begin
					flips++;
				end
				if (owed_drive.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result with no request outstanding", $realtime);
					end
				end else begin
					want = owed_drive.pop_front();
					field_check("left_fwd_duty", want.left_fwd_duty, rsp_if.left_fwd_duty);
					field_check("left_rev_duty", want.left_rev_duty, rsp_if.left_rev_duty);
					field_check("right_fwd_duty", want.right_fwd_duty, rsp_if.right_fwd_duty);
					field_check("right_rev_duty", want.right_rev_duty, rsp_if.right_rev_duty);
					field_check("left_reverse", want.left_reverse, rsp_if.left_reverse);
					field_check("right_reverse", want.right_reverse, rsp_if.right_reverse);
					field_check("bridge_cycled", want.bridge_cycled, rsp_if.bridge_cycled);
				end
			end
		end
	end

	// Offer one request, with random gaps ahead of it; called and returns at a falling edge.
	task automatic send_item(logic rt, logic [2:0] pos);
		while (tx_idle && $urandom_range(99) < 34) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.req_type      <= rt;
		req_if.line_position <= pos;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stop offering requests until every result has come back.
	task automatic drain();
		req_if.valid <= 1'b0;
		while (owed_drive.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic reg_write(logic [2:0] idx, logic [9:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Write all six registers, and optionally one spare index; spare upper data bits get random values the unit ignores.
	task automatic load_regs(cfg_t c, bit spare);
		logic [9:0] bits;
		bits = 10'($urandom);
		bits[1:0] = c.control_mode;
		reg_write(CFG_CONTROL_MODE, bits);
		reg_write(CFG_BASE_SPEED, c.base_speed);
		reg_write(CFG_INNER_CUT, c.inner_cut);
		reg_write(CFG_SPEED_FLOOR, c.speed_floor);
		bits = 10'($urandom);
		bits[7:0] = c.trim_l;
		reg_write(CFG_TRIM_L, bits);
		bits = 10'($urandom);
		bits[7:0] = c.trim_r;
		reg_write(CFG_TRIM_R, bits);
		if (spare) begin
			reg_write(CFG_IDX_SPARE + 3'($urandom_range(1)), 10'($urandom));
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic cfg_t rand_regs(mode_t m);
		int a, mn;
		a  = ($urandom_range(99) < 30) ? $urandom_range(150) : $urandom_range(1023);
		mn = ($urandom_range(99) < 70) ? $urandom_range(300) : $urandom_range(1023);
		return regs(m, a, $urandom_range(1023), mn, $urandom_range(255), $urandom_range(255));
	endfunction

	initial begin : stimulus
		plan_row_t  plan [$];
		plan_row_t  row;
		cfg_t       c;
		mode_t      m;
		logic       rt;
		logic [2:0] pos;
		int r;

		cfg_m = regs(MODE_BANG, 1000, 100, 0, 0, 0);
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		req_if.valid         = 1'b0;
		req_if.req_type      = REQ_UPDATE;
		req_if.line_position = POS_LEFT;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part; expectations typed in only where they are obvious.
		plan = '{
			row_known(REQ_ENABLE, POS_SPARE7,    duty(0, 0, 0, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_CENTER,    duty(1000, 0, 1000, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_LEFT,      duty(1000, 0, 1000, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_FAR_LEFT,  duty(0, 0, 1000, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_FAR_RIGHT, duty(1000, 0, 0, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_NONE,      duty(1000, 0, 0, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_SPARE6,    duty(1000, 0, 0, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_SPARE7,    duty(1000, 0, 0, 0, 0, 0, 0)),
			row_regs(regs(MODE_REDUCE, 1000, 1000, 0, -128, 127)),
			row_known(REQ_UPDATE, POS_LEFT,      duty(0, 128, 1000, 0, 1, 0, 1)),
			row_known(REQ_ENABLE, POS_RIGHT,     duty(0, 0, 0, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_RIGHT,     duty(872, 0, 127, 0, 0, 0, 0)),
			row_known(REQ_UPDATE, POS_FAR_LEFT,  duty(0, 0, 1000, 0, 0, 0, 0)),
			row_regs(regs(MODE_SMOOTH, 1000, 0, 0, 0, 0)),
			row_item(REQ_UPDATE, POS_CENTER),
			row_item(REQ_UPDATE, POS_LEFT),
			row_item(REQ_UPDATE, POS_RIGHT),
			row_item(REQ_UPDATE, POS_FAR_LEFT),
			row_item(REQ_UPDATE, POS_FAR_RIGHT),
			row_item(REQ_UPDATE, POS_NONE),
			row_regs(regs(MODE_SMOOTH, 0, 0, 1000, -100, 100)),
			row_item(REQ_UPDATE, POS_CENTER),
			row_item(REQ_UPDATE, POS_FAR_LEFT),
			row_item(REQ_ENABLE, POS_LEFT),
			row_regs(regs(MODE_HOLD, 500, 100, 0, 0, 0)),
			row_item(REQ_UPDATE, POS_LEFT),
			row_item(REQ_UPDATE, POS_FAR_RIGHT),
			row_item(REQ_UPDATE, POS_CENTER)
		};
		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg) begin
				drain();
				load_regs(row.cfg, 1'b0);
			end else begin
				known_valid = row.known;
				known_exp   = row.want;
				send_item(row.rtype, row.pos);
			end
		end
		known_valid = 1'b0;

		// Random phases: bang-bang, reduce and hold modes first so the accumulator climbs toward its cap,
		// then smooth tracking with far-heavy and near-line position mixes, and last a random mode.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0, 3:    m = MODE_BANG;
				1:       m = MODE_REDUCE;
				2:       m = MODE_HOLD;
				7:       m = mode_t'($urandom_range(3));
				default: m = MODE_SMOOTH;
			endcase
			if (ph == 1) begin
				c = regs(MODE_REDUCE, 0, 1023, 0, 127, -128);
			end else if (ph == 6) begin
				c = regs(MODE_SMOOTH, 1023, 0, 1023, 127, 127);
			end else begin
				c = rand_regs(m);
			end
			load_regs(c, 1'b1);
			tx_idle = (ph != 3);
			rx_idle = (ph != 3);
			if (ph == 2) begin
				hold_cycles = HOLD_CYCLES;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 5 && n == PHASE_ITEMS / 2) begin
					drain();
				end
				r = $urandom_range(99);
				if (r < 8) begin
					rt  = REQ_ENABLE;
					pos = 3'($urandom_range(7));
				end else begin
					rt = REQ_UPDATE;
					if (ph == 4) begin
						if (r < 60) begin
							pos = $urandom_range(1) ? POS_FAR_LEFT : POS_FAR_RIGHT;
						end else if (r < 80) begin
							pos = POS_NONE;
						end else begin
							pos = 3'($urandom_range(7));
						end
					end else if (ph == 5 && r < 90) begin
						pos = 3'($urandom_range(2));
					end else begin
						pos = 3'($urandom_range(7));
					end
				end
				send_item(rt, pos);
			end
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Covered %0d requests (%0d enables) over the directed table and %0d phases;",
			accepted, enables, PHASES);
		$display("%0d results checked, %0d bridge cycles, accumulator peak %0d.",
			results_seen, flips, accum_peak);
		if (mismatches == 0 && owed_drive.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
